@@ src/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// shared widths, operation codes and defaults for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int CAP_W         = 11;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int DEF_MAX_DEPTH = 1024;
    localparam int CAP_RESET     = 1024;

    // slave beat: mode, value, zero fill to whole bytes
    localparam int S_TDATA_W = ((MODE_W + DATA_W + 7) / 8) * 8;
    // master beat: ok, front_value, rear_value, is_empty, is_full
    localparam int M_FIELDS_W = 1 + DATA_W + DATA_W + 1 + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

@@ src/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue held in a ring memory of MAX_DEPTH+1 entries
// ----------------------------------------------------------------------------
// result path: an accepted beat updates the indices and writes the ring memory, the
//   registered ring read captures its values, then the output register loads the
//   result beat, later while the previous result still waits in the output register
// flow: a new item is not accepted until the result of the last one is loaded
// reset: head, tail, count and output valid clear; capacity returns to 1024
//   (clipped to MAX_DEPTH); the ring memory is not cleared
module circular_deque #(
    parameter int MAX_DEPTH = cdq_pkg::DEF_MAX_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // capacity register write
    input  logic                          i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]     i_cfg_wdata,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_axis_tdata,   // mode[2:0], value[34:3]
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cdq_pkg::M_TDATA_W-1:0] m_axis_tdata    // ok[0], front[32:1],
                                                          // rear[64:33], empty[65],
                                                          // full[66]
);
    import cdq_pkg::*;

    localparam int IW        = $clog2(MAX_DEPTH + 1);
    localparam int DEPTH     = MAX_DEPTH + 1;
    localparam int CAP_RST_I = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CAP_RESET;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    function automatic logic [IW-1:0] idx_up(input logic [IW-1:0] i, input logic [IW-1:0] c);
        idx_up = (i >= c) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_down(input logic [IW-1:0] i,
                                               input logic [IW-1:0] c);
        idx_down = (i == '0) ? c : i - 1'b1;
    endfunction

    logic [DATA_W-1:0] r_ring [DEPTH];

    logic              r_state, n_state;
    logic [IW-1:0]     r_cap;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [IW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_rd_front, r_rd_rear;
    logic [DATA_W-1:0] r_wval;
    logic              r_fwd_front, r_fwd_rear;
    logic              r_ok, r_empty, r_full;
    logic              r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    logic [MODE_W-1:0] w_mode;
    logic [DATA_W-1:0] w_value;
    logic              w_accept;
    logic              w_full, w_empty, w_ok;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [IW-1:0]     w_rear_addr;
    logic [31:0]       w_cfg32;
    logic [IW-1:0]     w_cfg_eff;
    logic              w_load;
    logic [DATA_W-1:0] w_front_out, w_rear_out;

    assign w_mode   = s_axis_tdata[MODE_W-1:0];
    assign w_value  = s_axis_tdata[MODE_W +: DATA_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_full  = (r_count >= r_cap);
    assign w_empty = (r_count == '0);

    // clip the written capacity to 1..MAX_DEPTH
    assign w_cfg32   = {{(32-CAP_W){1'b0}}, i_cfg_wdata};
    assign w_cfg_eff = (w_cfg32 == 32'd0) ? IW'(1) :
                       (w_cfg32 > 32'(MAX_DEPTH)) ? IW'(MAX_DEPTH) : w_cfg32[IW-1:0];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        w_ok    = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_tail;
        case (w_mode)
            MODE_PUSH_FRONT: begin
                if (!w_full) begin
                    n_head  = idx_down(r_head, r_cap);
                    w_waddr = n_head;
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_PUSH_REAR: begin
                if (!w_full) begin
                    w_waddr = r_tail;
                    w_we    = 1'b1;
                    n_tail  = idx_up(r_tail, r_cap);
                    n_count = r_count + 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (!w_empty) begin
                    n_head  = idx_up(r_head, r_cap);
                    n_count = r_count - 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (!w_empty) begin
                    n_tail  = idx_down(r_tail, r_cap);
                    n_count = r_count - 1'b1;
                    w_ok    = 1'b1;
                end
            end
            MODE_QUERY: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_rear_addr = idx_down(n_tail, r_cap);

    // ring memory: one write, two registered reads; same-slot reads use forwarding
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_ring[w_waddr] <= w_value;
        end
        if (w_accept) begin
            r_rd_front <= r_ring[n_head];
            r_rd_rear  <= r_ring[w_rear_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wval      <= w_value;
            r_fwd_front <= w_we && (w_waddr == n_head);
            r_fwd_rear  <= w_we && (w_waddr == w_rear_addr);
            r_ok        <= w_ok;
            r_empty     <= (n_count == '0);
            r_full      <= (n_count >= r_cap);
        end
    end

    assign w_front_out = r_empty ? EMPTY_VALUE : (r_fwd_front ? r_wval : r_rd_front);
    assign w_rear_out  = r_empty ? EMPTY_VALUE : (r_fwd_rear ? r_wval : r_rd_rear);
    assign w_load      = (r_state == ST_BUSY) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= IW'(CAP_RST_I);
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap   <= w_cfg_eff;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (w_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {{(M_TDATA_W-M_FIELDS_W){1'b0}},
                           r_full, r_empty, w_rear_out, w_front_out, r_ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ring span between head and tail must match the item count
    logic [IW:0] w_span;
    assign w_span = (r_tail >= r_head) ? ({1'b0, r_tail} - {1'b0, r_head}) :
                    ({1'b0, r_tail} + {1'b0, r_cap} + 1'b1 - {1'b0, r_head});

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("item count above capacity");

    a_span_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_span == {1'b0, r_count})
        else $error("head/tail span differs from item count");

    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_cap) && (r_tail <= r_cap))
        else $error("index outside ring");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_BUSY) && !s_axis_tready)
        else $error("accepted beat did not start work");

endmodule

@@ sim/circular_deque_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// drives mode/value beats into the deque and checks every result beat against
// a behavioral deque kept in the bench; covers refused inserts and removals,
// unknown modes, capacity clipping, clearing on capacity write and a full
// 1024-entry fill, then random traffic under changing capacities and stalls
// ----------------------------------------------------------------------------
module circular_deque_tb;
    import cdq_pkg::*;

    localparam int DEPTH       = DEF_MAX_DEPTH;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] rear_value;
        logic              is_empty;
        logic              is_full;
    } deque_result_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // mode[2:0], value[34:3]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // ok[0], front[32:1], rear[64:33],
                                                // empty[65], full[66]

    circular_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the deque
    logic [DATA_W-1:0] ring_model [0:DEPTH];
    logic [CAP_W-1:0]  head_idx   = '0;
    logic [CAP_W-1:0]  tail_idx   = '0;
    logic [CAP_W-1:0]  fill_count = '0;
    logic [CAP_W-1:0]  cap_reg    = CAP_W'(CAP_RESET);

    deque_result_t pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            src_idle_pct   = 20;
    int            sink_idle_pct  = 45;

    function automatic logic [CAP_W-1:0] active_cap();
        if (cap_reg == 0) return CAP_W'(1);
        if (cap_reg > DEPTH) return CAP_W'(DEPTH);
        return cap_reg;
    endfunction

    function automatic logic [CAP_W-1:0] step_up(logic [CAP_W-1:0] i, logic [CAP_W-1:0] cap);
        return (i >= cap) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [CAP_W-1:0] step_down(logic [CAP_W-1:0] i, logic [CAP_W-1:0] cap);
        return (i == 0 || i > cap) ? cap : i - 1'b1;
    endfunction

    function automatic deque_result_t apply_deque_op(logic [MODE_W-1:0] mode,
                                                     logic [DATA_W-1:0] value);
        logic [CAP_W-1:0] cap;
        logic             was_full;
        logic             was_empty;
        deque_result_t    r;
        cap       = active_cap();
        was_full  = (fill_count >= cap);
        was_empty = (fill_count == 0);
        r.ok      = 1'b0;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (!was_full) begin
                    head_idx             = step_down(head_idx, cap);
                    ring_model[head_idx] = value;
                    fill_count           = fill_count + 1'b1;
                    r.ok                 = 1'b1;
                end
            end
            MODE_PUSH_REAR: begin
                if (!was_full) begin
                    ring_model[tail_idx] = value;
                    tail_idx             = step_up(tail_idx, cap);
                    fill_count           = fill_count + 1'b1;
                    r.ok                 = 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (!was_empty) begin
                    head_idx   = step_up(head_idx, cap);
                    fill_count = fill_count - 1'b1;
                    r.ok       = 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (!was_empty) begin
                    tail_idx   = step_down(tail_idx, cap);
                    fill_count = fill_count - 1'b1;
                    r.ok       = 1'b1;
                end
            end
            MODE_QUERY: r.ok = 1'b1;
            default: ;
        endcase
        r.is_empty    = (fill_count == 0);
        r.is_full     = (fill_count >= cap);
        r.front_value = EMPTY_VALUE;
        r.rear_value  = EMPTY_VALUE;
        if (!r.is_empty) begin
            r.front_value = ring_model[head_idx];
            r.rear_value  = ring_model[step_down(tail_idx, cap)];
        end
        return r;
    endfunction

    // valid stays high from one beat to the next unless a gap is drawn
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        logic [S_TDATA_W-1:0] beat;
        beat                   = '0;
        beat[MODE_W-1:0]       = mode;
        beat[MODE_W +: DATA_W] = value;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_deque_op(mode, value));
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_reg    = cap;
        head_idx   = '0;
        tail_idx   = '0;
        fill_count = '0;
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] random_mode(int push_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return MODE_W'($urandom_range(5, 7));
        if (pick < 12) return MODE_QUERY;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
        return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
    endfunction

    // reset capacity, empty-deque refusals, unknown modes, extreme values
    task automatic test_directed_basics();
        send_beat(MODE_QUERY, $urandom);
        send_beat(MODE_POP_FRONT, $urandom);
        send_beat(MODE_POP_REAR, $urandom);
        send_beat(3'd5, $urandom);
        send_beat(3'd6, $urandom);
        send_beat(3'd7, $urandom);
        send_beat(MODE_PUSH_FRONT, 32'h8000_0000);
        send_beat(MODE_PUSH_REAR, 32'h7fff_ffff);
        send_beat(MODE_PUSH_FRONT, '0);
        send_beat(MODE_PUSH_REAR, '1);
        send_beat(MODE_QUERY, $urandom);
        send_beat(3'd5, $urandom);
        send_beat(3'd7, $urandom);
        send_beat(MODE_POP_FRONT, $urandom);
        send_beat(MODE_POP_REAR, $urandom);
        send_beat(MODE_POP_REAR, $urandom);
        send_beat(MODE_POP_FRONT, $urandom);
        send_beat(MODE_POP_FRONT, $urandom);
        send_beat(MODE_QUERY, $urandom);
    endtask

    // zero capacity acts as one; one and two exercise wrap at the smallest ring
    task automatic test_capacity_extremes();
        write_capacity('0);
        send_beat(MODE_PUSH_REAR, random_value());
        send_beat(MODE_PUSH_REAR, random_value());
        send_beat(MODE_PUSH_FRONT, random_value());
        send_beat(MODE_POP_FRONT, $urandom);
        send_beat(MODE_POP_REAR, $urandom);
        write_capacity(11'd1);
        send_beat(MODE_PUSH_FRONT, random_value());
        send_beat(MODE_PUSH_REAR, random_value());
        send_beat(MODE_POP_REAR, $urandom);
        write_capacity(11'd2);
        repeat (6) send_beat($urandom_range(1) ? MODE_PUSH_FRONT : MODE_POP_REAR, random_value());
    endtask

    task automatic test_clear_on_write();
        write_capacity(11'd3);
        send_beat(MODE_PUSH_REAR, random_value());
        send_beat(MODE_PUSH_FRONT, random_value());
        write_capacity(11'd3);
        send_beat(MODE_QUERY, $urandom);
        send_beat(MODE_POP_FRONT, $urandom);
    endtask

    // all-ones capacity clips to MAX_DEPTH, which is then filled
    task automatic test_fill_to_max();
        write_capacity('1);
        repeat (DEPTH) send_beat($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, $urandom);
        send_beat(MODE_PUSH_FRONT, $urandom);
        send_beat(MODE_PUSH_REAR, $urandom);
        send_beat(MODE_QUERY, $urandom);
        repeat (16) send_beat($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR, $urandom);
    endtask

    task automatic test_random_traffic(input int n_items);
        int               sent;
        int               n_session;
        int               push_pct;
        int               pick;
        logic [CAP_W-1:0] cap;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(19);
            if (pick == 0)      cap = '0;
            else if (pick == 1) cap = CAP_W'(DEPTH);
            else if (pick == 2) cap = CAP_W'($urandom);
            else                cap = CAP_W'($urandom_range(1, 12));
            write_capacity(cap);
            n_session = $urandom_range(30, 90);
            push_pct  = $urandom_range(30, 70);
            repeat (n_session) begin
                send_beat(random_mode(push_pct), random_value());
                sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        deque_result_t got;
        deque_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok          = m_axis_tdata[0];
            got.front_value = m_axis_tdata[32:1];
            got.rear_value  = m_axis_tdata[64:33];
            got.is_empty    = m_axis_tdata[65];
            got.is_full     = m_axis_tdata[66];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result beat with no pending expectation: %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
                check_field("front_value", want.front_value, got.front_value);
                check_field("rear_value", want.rear_value, got.rear_value);
                check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
                check_field("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_capacity_extremes();
        test_clear_on_write();
        test_fill_to_max();
        test_random_traffic(130);
        src_idle_pct  = 45;
        sink_idle_pct = 20;
        test_random_traffic(130);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(130);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
